/* rtl/core/circular_double_ended_queue_macros.svh */
// Assertion helpers used by the deque datapath.
// Each macro expands to one labeled concurrent assertion, disabled in reset.
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_MACROS_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/cdq_pkg.sv */
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants of the circular double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

  localparam int unsigned MAX_DEPTH = 16;
  localparam int unsigned ADDR_W    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_DEPTH + 1);
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CAP_RESET = (16 > MAX_DEPTH) ? MAX_DEPTH : 16;

  // Operation codes; codes above KIND_PEEK act as a peek.
  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_PUSH_REAR  = 3'd1;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [2:0] KIND_POP_REAR   = 3'd3;
  localparam logic [2:0] KIND_PEEK       = 3'd4;

  typedef struct packed {
    logic [2:0]               kind;
    logic signed [WORD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] rear_value;
    logic [4:0]               entry_count;
    logic                     is_empty;
    logic                     is_full;
    logic                     rejected;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_item;
    logic exec;
    logic load_out;
    logic cfg_write;
  } cdq_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;
  } cdq_status_t;

endpackage

`default_nettype wire

/* rtl/core/cdq_ram.sv */
// ----------------------------------------------------------------------------
// cdq_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                         wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_a_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_b_i,
  output logic      [Width-1:0]                         rdata_a_o,
  output logic      [Width-1:0]                         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

/* rtl/core/cdq_ctrl.sv */
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer of the deque: accept, execute, read back, load the result; capacity writes are granted while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ctrl
  import cdq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  output cdq_cmd_t         cmd_o,
  input  wire cdq_status_t status_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_LOAD = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.cfg_write = cfg_valid_i && cfg_ready_o;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_READ;
      end
      // The RAM samples the updated pointers here.
      ST_READ: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cdq_datapath.sv */
// ----------------------------------------------------------------------------
// cdq_datapath
// Pointers, count, capacity, word store and result register of the deque.
// ----------------------------------------------------------------------------
`default_nettype none

`include "circular_double_ended_queue_macros.svh"

module cdq_datapath
  import cdq_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cdq_cmd_t         cmd_i,
  output cdq_status_t           status_o,
  input  wire in_item_t         in_item_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output out_item_t             out_item_o
);

  logic [2:0]        kind_q;
  logic [WORD_W-1:0] value_q;
  logic [ADDR_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d, cap_q, cap_d;
  logic              rej_q, rej_d;
  logic              out_valid_q;
  out_item_t         out_q;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [WORD_W-1:0] rdata_front, rdata_rear;
  logic              full;

  function automatic logic [ADDR_W-1:0] step_up(input logic [ADDR_W-1:0] idx,
                                                input logic [CNT_W-1:0]  cap);
    logic [CNT_W-1:0] nxt;
    nxt = CNT_W'(idx) + CNT_W'(1);
    return (nxt >= cap) ? '0 : ADDR_W'(nxt);
  endfunction

  function automatic logic [ADDR_W-1:0] step_down(input logic [ADDR_W-1:0] idx,
                                                  input logic [CNT_W-1:0]  cap);
    logic [CNT_W-1:0] top;
    top = cap - CNT_W'(1);
    return (idx == '0) ? ADDR_W'(top) : idx - ADDR_W'(1);
  endfunction

  assign full = (count_q >= cap_q);

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    cap_d   = cap_q;
    rej_d   = rej_q;
    we      = 1'b0;
    waddr   = '0;
    if (cmd_i.exec) begin
      rej_d = 1'b0;
      case (kind_q)
        KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
          if (full) begin
            rej_d = 1'b1;
          end else begin
            if (count_q == '0) begin
              head_d = '0;
              tail_d = '0;
              waddr  = '0;
            end else if (kind_q == KIND_PUSH_FRONT) begin
              head_d = step_down(head_q, cap_q);
              waddr  = head_d;
            end else begin
              tail_d = step_up(tail_q, cap_q);
              waddr  = tail_d;
            end
            we      = 1'b1;
            count_d = count_q + CNT_W'(1);
          end
        end
        KIND_POP_FRONT, KIND_POP_REAR: begin
          if (count_q == '0) begin
            rej_d = 1'b1;
          end else begin
            // Removing the last word puts the pointers back to their reset place.
            if (count_q == CNT_W'(1)) begin
              head_d = '0;
              tail_d = '0;
            end else if (kind_q == KIND_POP_FRONT) begin
              head_d = step_up(head_q, cap_q);
            end else begin
              tail_d = step_down(tail_q, cap_q);
            end
            count_d = count_q - CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
    // Capacity changes only take effect on an empty deque.
    if (cmd_i.cfg_write && (count_q == '0)) begin
      head_d = '0;
      tail_d = '0;
      if (cfg_data_i == '0) begin
        cap_d = CNT_W'(1);
      end else if (32'(cfg_data_i) > 32'(MAX_DEPTH)) begin
        cap_d = CNT_W'(MAX_DEPTH);
      end else begin
        cap_d = CNT_W'(cfg_data_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      cap_q       <= CNT_W'(CAP_RESET);
      rej_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      cap_q   <= cap_d;
      rej_q   <= rej_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      kind_q  <= in_item_i.kind;
      value_q <= in_item_i.value;
    end
    if (cmd_i.load_out) begin
      out_q.front_value <= (count_q == '0) ? '1 : rdata_front;
      out_q.rear_value  <= (count_q == '0) ? '1 : rdata_rear;
      out_q.entry_count <= 5'(count_q);
      out_q.is_empty    <= (count_q == '0);
      out_q.is_full     <= (count_q == cap_q);
      out_q.rejected    <= rej_q;
    end
  end

  cdq_ram #(
    .Width(WORD_W),
    .Depth(MAX_DEPTH)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (value_q),
    .raddr_a_i(head_q),
    .raddr_b_i(tail_q),
    .rdata_a_o(rdata_front),
    .rdata_b_o(rdata_rear)
  );

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_item_o        = out_q;

  `CDQ_ASSERT_NOW(a_count_within_cap, clk_i, rst_ni, 1'b1, count_q <= cap_q, "count above capacity")
  `CDQ_ASSERT_NOW(a_cap_in_range, clk_i, rst_ni, 1'b1, (cap_q != '0) && (32'(cap_q) <= 32'(MAX_DEPTH)), "capacity out of range")
  `CDQ_ASSERT_NOW(a_empty_ptrs_home, clk_i, rst_ni, count_q == '0, (head_q == '0) && (tail_q == '0), "empty deque with moved pointers")
  `CDQ_ASSERT_NEXT(a_reject_keeps_count, clk_i, rst_ni, cmd_i.exec && rej_d, $stable(count_q), "refused operation changed the count")

endmodule

`default_nettype wire

/* rtl/core/circular_double_ended_queue.sv */
// ----------------------------------------------------------------------------
// circular_double_ended_queue
// Double-ended queue of signed 32-bit words in a circular store.
//
//   Channel   Direction  Handshake                 Payload
//   in        input      in_valid_i / in_ready_o   in_item_i  (in_item_t)
//   out       output     out_valid_o / out_ready_i out_item_o (out_item_t)
//   cfg       input      cfg_valid_i / cfg_ready_o cfg_data_i (capacity)
//
// An item is handled in order: accept, execute (pointer update and store write),
// read of the front and rear entries through the registered RAM port, and load
// of the result register. The store has a single write port. The result register
// lets the next item start while a result is still waiting; the last step waits
// as long as that register stays full.
// After reset the deque is empty with capacity 16; the store needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_double_ended_queue
  import cdq_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire in_item_t         in_item_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output out_item_t             out_item_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CFG_W-1:0] cfg_data_i
);

  cdq_cmd_t    cmd;
  cdq_status_t status;

  cdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  cdq_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_item_i  (in_item_i),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire
